>>> sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, ignored while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> sv/edc_pkg.sv
// Shared types and constants for the elevator dispatch controller.
`timescale 1ns / 1ps

package edc_pkg;

    localparam int FLOORS  = 4;
    localparam int FLOOR_W = 2;

    typedef logic [FLOORS-1:0] mask_t;
    typedef logic signed [1:0] dir_t;

    localparam dir_t DIR_UP   = 2'sb01;
    localparam dir_t DIR_DOWN = 2'sb11;
    localparam dir_t DIR_STOP = 2'sb00;

    typedef enum logic [2:0] {
        M_IDLE         = 3'd0,
        M_MOVE         = 3'd1,
        M_STOP_AT      = 3'd2,
        M_STOP_BETWEEN = 3'd3,
        M_DOOR         = 3'd4
    } mode_t;

    // Event transaction.
    typedef struct packed {
        logic [2:0]         mode;
        logic [FLOOR_W-1:0] floor;
        logic [1:0]         button;
        logic               at_floor;
    } evt_t;

    // Status transaction.
    typedef struct packed {
        dir_t       motor_dir;
        logic       door_lamp;
        logic       stop_lamp;
        logic       timer_go;
        logic [3:0] up_calls;
        logic [3:0] down_calls;
        logic [3:0] cab_calls;
        logic [2:0] mode_now;
    } res_t;

    // Controller state.
    typedef struct packed {
        mode_t              mode;
        logic [FLOOR_W-1:0] cur_floor;
        dir_t               dir;
        logic               between;
        mask_t              up_mask;
        mask_t              down_mask;
        mask_t              cab_mask;
        dir_t               motor;
        logic               door;
        logic               stop;
    } state_t;

endpackage

>>> sv/edc_step.sv
// Next-state and status logic for one event of the elevator controller.
`timescale 1ns / 1ps

module edc_step
(
    input  edc_pkg::state_t cur,
    input  edc_pkg::evt_t   evt,
    output edc_pkg::state_t nxt,
    output edc_pkg::res_t   res
);

    localparam int FW = edc_pkg::FLOOR_W;
    localparam int NF = edc_pkg::FLOORS;

    localparam edc_pkg::mask_t BOT_BIT   = edc_pkg::mask_t'(1);
    localparam edc_pkg::mask_t TOP_BIT   = edc_pkg::mask_t'(1) << (NF - 1);
    localparam logic [FW-1:0]  TOP_FLOOR = FW'(NF - 1);
    localparam logic [FW-1:0]  BOT_FLOOR = FW'(0);

    typedef enum logic [2:0] {
        EV_STOP_PRESS   = 3'd0,
        EV_STOP_RELEASE = 3'd1,
        EV_ARRIVE       = 3'd2,
        EV_ORDER        = 3'd3,
        EV_TIMEOUT      = 3'd4,
        EV_POLL         = 3'd5
    } event_t;

    localparam logic [1:0] BTN_UP   = 2'd0;
    localparam logic [1:0] BTN_DOWN = 2'd1;
    localparam logic [1:0] BTN_CAB  = 2'd2;

    function automatic edc_pkg::mask_t floor_bit(logic [FW-1:0] f);
        return edc_pkg::mask_t'(1) << f;
    endfunction

    function automatic logic orders_above(logic [FW-1:0] f, edc_pkg::mask_t up,
                                          edc_pkg::mask_t dn, edc_pkg::mask_t cab);
        edc_pkg::mask_t above;
        edc_pkg::mask_t up_rng;
        for (int i = 0; i < NF; i++)
        begin
            above[i] = (i > int'(f));
        end
        up_rng = above & ~TOP_BIT;
        return (|(up & up_rng)) || (|((dn | cab) & above));
    endfunction

    function automatic logic orders_below(logic [FW-1:0] f, edc_pkg::mask_t up,
                                          edc_pkg::mask_t dn, edc_pkg::mask_t cab);
        edc_pkg::mask_t below;
        edc_pkg::mask_t dn_rng;
        for (int i = 0; i < NF; i++)
        begin
            below[i] = (i < int'(f));
        end
        dn_rng = below & ~BOT_BIT;
        return (|(dn & dn_rng)) || (|((up | cab) & below));
    endfunction

    function automatic edc_pkg::state_t open_car_door(edc_pkg::state_t s);
        edc_pkg::state_t r;
        r       = s;
        r.mode  = edc_pkg::M_DOOR;
        r.motor = edc_pkg::DIR_STOP;
        r.door  = 1'b1;
        return r;
    endfunction

    edc_pkg::mask_t  fbit;
    edc_pkg::mask_t  cbit;
    logic            f_ok;
    logic            order_ok;
    // arrival
    logic            cab_hit;
    logic            up_hit;
    logic            dn_hit;
    logic            arr_above;
    logic            arr_below;
    // direction search
    logic            going_up;
    logic            here_any;
    logic            srv_cab;
    logic            srv_up;
    logic            srv_dn;
    logic            cur_above;
    logic            cur_below;
    logic            ch_go;
    logic            ch_pulse;
    edc_pkg::state_t chs;
    logic            pulse;

    // Direction search from the current floor.
    always_comb
    begin
        going_up  = (cur.dir == edc_pkg::DIR_UP);
        cbit      = floor_bit(cur.cur_floor);
        here_any  = |((cur.up_mask | cur.down_mask | cur.cab_mask) & cbit);
        srv_cab   = |(cur.cab_mask & cbit);
        srv_up    = (|(cur.up_mask & cbit)) && (cur.cur_floor != TOP_FLOOR);
        srv_dn    = (|(cur.down_mask & cbit)) && (cur.cur_floor != BOT_FLOOR);
        cur_above = orders_above(cur.cur_floor, cur.up_mask, cur.down_mask, cur.cab_mask);
        cur_below = orders_below(cur.cur_floor, cur.up_mask, cur.down_mask, cur.cab_mask);

        chs      = cur;
        ch_go    = 1'b1;
        ch_pulse = 1'b0;
        if (cur.between && here_any)
        begin
            // stopped between floors with an order here: head back the other way
            chs.dir     = going_up ? edc_pkg::DIR_DOWN : edc_pkg::DIR_UP;
            chs.between = 1'b0;
        end
        else if (srv_cab || srv_up || srv_dn)
        begin
            if (srv_cab)
                chs.cab_mask = cur.cab_mask & ~cbit;
            if (srv_up)
                chs.up_mask = cur.up_mask & ~cbit;
            if (srv_dn)
                chs.down_mask = cur.down_mask & ~cbit;
            chs      = open_car_door(chs);
            chs.dir  = edc_pkg::DIR_STOP;
            ch_pulse = 1'b1;
        end
        else if (going_up && cur_above)
        begin
            chs.between = 1'b0;
        end
        else if (cur_below)
        begin
            chs.dir     = edc_pkg::DIR_DOWN;
            chs.between = 1'b0;
        end
        else if (!going_up && cur_above)
        begin
            chs.dir     = edc_pkg::DIR_UP;
            chs.between = 1'b0;
        end
        else
        begin
            ch_go = 1'b0;
        end
    end

    // Event decode.
    always_comb
    begin
        fbit      = floor_bit(evt.floor);
        f_ok      = (int'(evt.floor) < NF);
        order_ok  = (cur.mode == edc_pkg::M_IDLE) || (cur.mode == edc_pkg::M_MOVE) ||
                    (cur.mode == edc_pkg::M_DOOR);
        cab_hit   = |(cur.cab_mask & fbit);
        up_hit    = (|(cur.up_mask & fbit)) && (evt.floor != TOP_FLOOR) &&
                    (cur.dir == edc_pkg::DIR_UP);
        dn_hit    = (|(cur.down_mask & fbit)) && (evt.floor != BOT_FLOOR) &&
                    (cur.dir == edc_pkg::DIR_DOWN);
        arr_above = orders_above(evt.floor, cur.up_mask, cur.down_mask, cur.cab_mask);
        arr_below = orders_below(evt.floor, cur.up_mask, cur.down_mask, cur.cab_mask);

        nxt   = cur;
        pulse = 1'b0;
        unique case (event_t'(evt.mode))
            EV_STOP_PRESS:
            begin
                nxt.stop      = 1'b1;
                nxt.motor     = edc_pkg::DIR_STOP;
                nxt.up_mask   = '0;
                nxt.down_mask = '0;
                nxt.cab_mask  = '0;
                if (evt.at_floor)
                begin
                    nxt.mode = edc_pkg::M_STOP_AT;
                    nxt.door = 1'b1;
                end
                else
                begin
                    nxt.mode    = edc_pkg::M_STOP_BETWEEN;
                    nxt.between = 1'b1;
                end
            end
            EV_STOP_RELEASE:
            begin
                if (cur.mode == edc_pkg::M_STOP_AT)
                begin
                    // door opens, but the controller rests in idle
                    nxt      = open_car_door(cur);
                    nxt.mode = edc_pkg::M_IDLE;
                    pulse    = 1'b1;
                end
                else if (cur.mode == edc_pkg::M_STOP_BETWEEN)
                begin
                    nxt.mode = edc_pkg::M_IDLE;
                end
                nxt.stop = 1'b0;
            end
            EV_ARRIVE:
            begin
                if (f_ok)
                begin
                    nxt.cur_floor = evt.floor;
                    if (cab_hit)
                        nxt.cab_mask = cur.cab_mask & ~fbit;
                    if (up_hit || dn_hit)
                    begin
                        nxt.up_mask   = cur.up_mask & ~fbit;
                        nxt.down_mask = cur.down_mask & ~fbit;
                    end
                    if (cab_hit || up_hit || dn_hit)
                    begin
                        nxt   = open_car_door(nxt);
                        pulse = 1'b1;
                    end
                    else if (cur.mode != edc_pkg::M_DOOR)
                    begin
                        // last order in this direction is a call the other way
                        if ((cur.dir == edc_pkg::DIR_UP) && !arr_above &&
                            (|(cur.down_mask & fbit)))
                        begin
                            nxt.dir       = edc_pkg::DIR_STOP;
                            nxt.down_mask = cur.down_mask & ~fbit;
                            nxt           = open_car_door(nxt);
                            pulse         = 1'b1;
                        end
                        else if ((cur.dir == edc_pkg::DIR_DOWN) && !arr_below &&
                                 (|(cur.up_mask & fbit)))
                        begin
                            nxt.dir     = edc_pkg::DIR_STOP;
                            nxt.up_mask = cur.up_mask & ~fbit;
                            nxt         = open_car_door(nxt);
                            pulse       = 1'b1;
                        end
                    end
                end
            end
            EV_ORDER:
            begin
                if (f_ok && order_ok)
                begin
                    if ((evt.button == BTN_UP) && (evt.floor != TOP_FLOOR))
                        nxt.up_mask = cur.up_mask | fbit;
                    else if ((evt.button == BTN_DOWN) && (evt.floor != BOT_FLOOR))
                        nxt.down_mask = cur.down_mask | fbit;
                    else if (evt.button == BTN_CAB)
                        nxt.cab_mask = cur.cab_mask | fbit;
                end
            end
            EV_TIMEOUT:
            begin
                nxt      = chs;
                nxt.door = ch_pulse;
                pulse    = ch_pulse;
                if (ch_go)
                begin
                    nxt.motor = chs.dir;
                    nxt.mode  = edc_pkg::M_MOVE;
                end
                else
                begin
                    nxt.mode = edc_pkg::M_IDLE;
                end
            end
            EV_POLL:
            begin
                if ((cur.mode == edc_pkg::M_IDLE) && ch_go)
                begin
                    nxt       = chs;
                    nxt.motor = chs.dir;
                    nxt.mode  = edc_pkg::M_MOVE;
                    pulse     = ch_pulse;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

    always_comb
    begin
        res.motor_dir  = nxt.motor;
        res.door_lamp  = nxt.door;
        res.stop_lamp  = nxt.stop;
        res.timer_go   = pulse;
        res.up_calls   = nxt.up_mask;
        res.down_calls = nxt.down_mask;
        res.cab_calls  = nxt.cab_mask;
        res.mode_now   = nxt.mode;
    end

endmodule

>>> sv/elevator_dispatch_controller_core.sv
// Top level of the elevator dispatch controller: event register, state, status register.
// Path from event acceptance to status valid: event register, then status register.
// Throughput: one event per cycle while res_stall is low; an empty event register takes
// a new transaction while a finished status transaction still waits downstream.
// Reset (rst_n low, async): idle, floor 0, heading up, all orders clear, lamps off.
`timescale 1ns / 1ps

module elevator_dispatch_controller_core
(
    input  logic            clk,
    input  logic            rst_n,
    // event channel
    input  logic            evt_valid,
    output logic            evt_stall,
    input  edc_pkg::evt_t   evt,
    // status channel
    output logic            res_valid,
    input  logic            res_stall,
    output edc_pkg::res_t   res
);

    // Two-stage pipe: an event sits in evt_reg, then its status lands in res_reg
    // in the same edge that commits the new controller state.
    logic            evt_vld_reg;
    logic            evt_vld_next;
    edc_pkg::evt_t   evt_reg;
    logic            res_vld_reg;
    logic            res_vld_next;
    edc_pkg::res_t   res_reg;
    edc_pkg::state_t state_reg;
    edc_pkg::state_t state_next;

    edc_pkg::state_t step_state;
    edc_pkg::res_t   step_res;

    logic            take;
    logic            adv;

    // The held event moves on when the status slot is free or being emptied.
    assign adv       = evt_vld_reg && (!res_vld_reg || !res_stall);
    assign evt_stall = evt_vld_reg && !adv;
    assign take      = evt_valid && !evt_stall;

    edc_step u_step
    (
        .cur (state_reg),
        .evt (evt_reg),
        .nxt (step_state),
        .res (step_res)
    );

    always_comb
    begin
        evt_vld_next = take ? 1'b1 : (adv ? 1'b0 : evt_vld_reg);
        res_vld_next = adv ? 1'b1 : (res_stall ? res_vld_reg : 1'b0);
        state_next   = adv ? step_state : state_reg;
    end

    // Control and controller state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_vld_reg         <= 1'b0;
            res_vld_reg         <= 1'b0;
            state_reg.mode      <= edc_pkg::M_IDLE;
            state_reg.cur_floor <= '0;
            state_reg.dir       <= edc_pkg::DIR_UP;
            state_reg.between   <= 1'b0;
            state_reg.up_mask   <= '0;
            state_reg.down_mask <= '0;
            state_reg.cab_mask  <= '0;
            state_reg.motor     <= edc_pkg::DIR_STOP;
            state_reg.door      <= 1'b0;
            state_reg.stop      <= 1'b0;
        end
        else
        begin
            evt_vld_reg <= evt_vld_next;
            res_vld_reg <= res_vld_next;
            state_reg   <= state_next;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        if (take)
            evt_reg <= evt;
        if (adv)
            res_reg <= step_res;
    end

    assign res_valid = res_vld_reg;
    assign res       = res_reg;

endmodule

>>> sv/edc_checker.sv
// Port-level checks for the elevator dispatch controller, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module edc_checker
(
    input logic          clk,
    input logic          rst_n,
    input logic          res_valid,
    input logic          res_stall,
    input edc_pkg::res_t res
);

    logic door_mode;
    logic motor_off;

    assign door_mode = res_valid && (res.mode_now == edc_pkg::M_DOOR);
    assign motor_off = (res.motor_dir == edc_pkg::DIR_STOP);

    // stalled status transaction holds
    `ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && res_stall, res_valid && $stable(res))

    // a timer start always comes with the door lamp on
    `ASSERT_IMPLY(a_pulse_door, clk, rst_n, res_valid && res.timer_go, res.door_lamp)

    // motor never runs while the door is open
    `ASSERT_IMPLY(a_door_still, clk, rst_n, door_mode, motor_off)

endmodule

bind elevator_dispatch_controller_core edc_checker u_edc_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);
